// ----- rtl/skl_pkg.sv -----
package skl_pkg;

	// field widths
	localparam int DATA_W = 32;
	localparam int ACC_W  = 48;
	localparam int FRAC_W = 16;

	// datapath widths
	localparam int SUM_W  = DATA_W + 1;          // v1 + v2
	localparam int SQ_W   = 2 * DATA_W;          // squares and v1 * v2, Q32.32
	localparam int NMUL_W = SQ_W + SUM_W;        // d^2 * (v1 + v2), Q49.48
	localparam int NUM_W  = NMUL_W + 1;          // full numerator
	localparam int DEN_W  = SQ_W;
	localparam int QUO_W  = ACC_W;

	localparam logic [DATA_W-1:0] MIN_VAR_RESET = 32'd655360;
	localparam logic [ACC_W-1:0]  ACC_MAX       = '1;

endpackage

// ----- rtl/skl_if.sv -----
interface skl_dim_if;
	logic                              valid;
	logic                              ready;
	logic signed [skl_pkg::DATA_W-1:0] mean_a;
	logic        [skl_pkg::DATA_W-1:0] var_a;
	logic signed [skl_pkg::DATA_W-1:0] mean_b;
	logic        [skl_pkg::DATA_W-1:0] var_b;
	logic                              final_dim;

	modport source (output valid, mean_a, var_a, mean_b, var_b, final_dim, input ready);
	modport sink (input valid, mean_a, var_a, mean_b, var_b, final_dim, output ready);
endinterface

interface skl_res_if;
	logic                       valid;
	logic                       ready;
	logic [skl_pkg::ACC_W-1:0]  divergence;
	logic                       saturated;

	modport source (output valid, divergence, saturated, input ready);
	modport sink (input valid, divergence, saturated, output ready);
endinterface

// ----- rtl/symmetric_kl_diag_gaussian.sv -----
// symmetric kl divergence of two diagonal gaussians, summed over dimensions
//
// dim channel: one item per dimension with mean_a, var_a, mean_b, var_b (q16.16)
// and final_dim; an item is taken when valid and ready are both high
// res channel: one item per group of dimensions, sent after the item that
// carries final_dim: divergence (unsigned q32.16, saturating) and saturated
// cfg_we / cfg_data: writes min_variance (q16.16 floor on both variances)
//
// flow: ready is high only while idle, so a new dimension is taken only after
// the last one has been accumulated. the two rounds of bit-serial multiplies
// (32-bit then 33-bit multipliers) and the restoring divider take most of each dimension
// path: prep, both multiply rounds, divider, then accumulate registers the result item
// reset: total and clip flag cleared, floor back to 10.0, no result pending
// stall: the result sits in an output register; new dimensions are still
// taken while it waits, and only the next final dimension holds at its
// accumulate step until the old result has gone
module symmetric_kl_diag_gaussian (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [skl_pkg::DATA_W-1:0]  cfg_data,
	skl_dim_if.sink                     dim,
	skl_res_if.source                   res
);

	localparam int DW = skl_pkg::DATA_W;
	localparam int AW = skl_pkg::ACC_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_START1 = 3'd2;
	localparam logic [2:0] S_MUL1   = 3'd3;
	localparam logic [2:0] S_MUL2   = 3'd4;
	localparam logic [2:0] S_DIV0   = 3'd5;
	localparam logic [2:0] S_DIV    = 3'd6;
	localparam logic [2:0] S_ACC    = 3'd7;

	logic [2:0]                    state_q;
	logic [DW-1:0]                 min_var_q;

	// accepted item
	logic signed [DW-1:0]          mean_a_q;
	logic signed [DW-1:0]          mean_b_q;
	logic [DW-1:0]                 var_a_q;
	logic [DW-1:0]                 var_b_q;
	logic                          final_q;

	// prepared operands
	logic [DW-1:0]                 v1_q;
	logic [DW-1:0]                 v2_q;
	logic [DW-1:0]                 ad_q;
	logic [skl_pkg::SUM_W-1:0]     vsum_q;
	logic [skl_pkg::NUM_W-1:0]     num_q;
	logic [AW-1:0]                 term_q;
	logic                          term_over_q;

	// accumulator and result
	logic [AW-1:0]                 total_q;
	logic                          clip_q;
	logic                          out_valid_q;
	logic [AW-1:0]                 out_div_q;
	logic                          out_sat_q;

	logic                          accept;
	logic [DW-1:0]                 floor_v;
	logic [DW:0]                   d;
	logic [DW:0]                   d_neg;
	logic [DW-1:0]                 vdiff;
	logic                          start1;
	logic                          start2;
	logic                          div_start;
	logic                          advance;
	logic [AW:0]                   sum;
	logic [AW-1:0]                 new_total;
	logic                          clip_new;

	logic                          dd_busy;
	logic                          dd_done;
	logic [skl_pkg::SQ_W-1:0]      dd_p;
	logic [skl_pkg::SQ_W-1:0]      vv_p;
	logic [skl_pkg::SQ_W-1:0]      den_p;
	logic                          num_done;
	logic [skl_pkg::NMUL_W-1:0]    num_p;
	logic                          div_busy;
	logic                          div_done;
	logic                          div_over;
	logic [AW-1:0]                 div_quo;

	assign accept    = dim.valid && dim.ready;
	assign dim.ready = (state_q == S_IDLE);

	// a floor of zero still keeps every variance at one lsb or more
	assign floor_v = (min_var_q == '0) ? DW'(1) : min_var_q;

	// mean difference in 33 bits, magnitude always fits 32
	assign d     = {mean_a_q[DW-1], mean_a_q} - {mean_b_q[DW-1], mean_b_q};
	assign d_neg = -d;
	assign vdiff = (v1_q > v2_q) ? (v1_q - v2_q) : (v2_q - v1_q);

	assign start1    = (state_q == S_START1);
	assign start2    = (state_q == S_MUL1) && dd_done;
	assign div_start = (state_q == S_DIV0);

	// saturating accumulate
	assign sum       = {1'b0, total_q} + {1'b0, term_q};
	assign new_total = sum[AW] ? skl_pkg::ACC_MAX : sum[AW-1:0];
	assign clip_new  = clip_q || sum[AW] || term_over_q;
	assign advance   = (state_q == S_ACC) && (!final_q || !out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_var_q   <= skl_pkg::MIN_VAR_RESET;
			total_q     <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_var_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_PREP;
				end
				S_PREP:   state_q <= S_START1;
				S_START1: state_q <= S_MUL1;
				S_MUL1: begin
					if (dd_done) state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (num_done) state_q <= S_DIV0;
				end
				S_DIV0:   state_q <= S_DIV;
				S_DIV: begin
					if (div_done) state_q <= S_ACC;
				end
				S_ACC: begin
					if (advance) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
			if (advance) begin
				if (final_q) begin
					total_q <= '0;
					clip_q  <= 1'b0;
				end else begin
					total_q <= new_total;
					clip_q  <= clip_new;
				end
			end
			if (advance && final_q) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mean_a_q <= dim.mean_a;
			mean_b_q <= dim.mean_b;
			var_a_q  <= dim.var_a;
			var_b_q  <= dim.var_b;
			final_q  <= dim.final_dim;
		end
		if (state_q == S_PREP) begin
			v1_q <= (var_a_q < floor_v) ? floor_v : var_a_q;
			v2_q <= (var_b_q < floor_v) ? floor_v : var_b_q;
			ad_q <= d[DW] ? d_neg[DW-1:0] : d[DW-1:0];
		end
		if (start1) begin
			vsum_q <= {1'b0, v1_q} + {1'b0, v2_q};
		end
		// numerator in q50.48: d^2 (v1 + v2) + (v1 - v2)^2 aligned up by 16
		if ((state_q == S_MUL2) && num_done) begin
			num_q <= skl_pkg::NUM_W'(num_p)
				+ skl_pkg::NUM_W'({vv_p, {skl_pkg::FRAC_W{1'b0}}});
		end
		if ((state_q == S_DIV) && div_done) begin
			term_q      <= div_over ? skl_pkg::ACC_MAX : div_quo;
			term_over_q <= div_over;
		end
		if (advance && final_q) begin
			out_div_q <= new_total;
			out_sat_q <= clip_new;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.divergence = out_div_q;
	assign res.saturated  = out_sat_q;

	// first round: d^2, (v1 - v2)^2 and v1 * v2 side by side
	skl_sermul #(.WA(DW), .WB(DW)) u_mul_dd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start1),
		.a      (ad_q),
		.b      (ad_q),
		.busy   (dd_busy),
		.done   (dd_done),
		.p      (dd_p)
	);

	skl_sermul #(.WA(DW), .WB(DW)) u_mul_vv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start1),
		.a      (vdiff),
		.b      (vdiff),
		.busy   (),
		.done   (),
		.p      (vv_p)
	);

	skl_sermul #(.WA(DW), .WB(DW)) u_mul_den (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start1),
		.a      (v1_q),
		.b      (v2_q),
		.busy   (),
		.done   (),
		.p      (den_p)
	);

	// second round: d^2 * (v1 + v2)
	skl_sermul #(.WA(skl_pkg::SQ_W), .WB(skl_pkg::SUM_W)) u_mul_num (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start2),
		.a      (dd_p),
		.b      (vsum_q),
		.busy   (),
		.done   (num_done),
		.p      (num_p)
	);

	skl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_p),
		.busy   (div_busy),
		.done   (div_done),
		.over   (div_over),
		.quo    (div_quo)
	);

	// multiplier round and divider never overlap
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(dd_busy && div_busy))
		else $error("multiplier and divider busy together");

	// divider only finishes while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	// emission clears the accumulator and presents a result
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_q) |=> (res.valid && total_q == '0 && !clip_q))
		else $error("final dimension did not emit and clear");

	// any clipping on a non-final dimension is remembered
	a_clip_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !final_q && (sum[AW] || term_over_q)) |=> clip_q)
		else $error("clip not recorded");

endmodule

// ----- rtl/skl_sermul.sv -----
// radix-2 shift-add multiplier, one multiplier bit per cycle
module skl_sermul #(
	parameter int WA = skl_pkg::DATA_W,
	parameter int WB = skl_pkg::DATA_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WA-1:0]     a,
	input  logic [WB-1:0]     b,
	output logic              busy,
	output logic              done,
	output logic [WA+WB-1:0]  p
);

	localparam int CW = $clog2(WB + 1);

	logic [WA-1:0]    a_q;
	logic [WA+WB-1:0] p_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WA:0]      sum;

	assign sum = {1'b0, p_q[WA+WB-1:WB]} + (p_q[0] ? {1'b0, a_q} : {(WA+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{WA{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[WB-1:1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p    = p_q;

endmodule

// ----- rtl/skl_divider.sv -----
// restoring divider, one quotient bit per cycle, with an overflow flag
module skl_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [skl_pkg::NUM_W-1:0]   num,
	input  logic [skl_pkg::DEN_W-1:0]   den,
	output logic                        busy,
	output logic                        done,
	output logic                        over,
	output logic [skl_pkg::QUO_W-1:0]   quo
);

	localparam int DW = skl_pkg::DEN_W;
	localparam int QW = skl_pkg::QUO_W;
	localparam int NW = skl_pkg::NUM_W;
	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [DW-1:0] den_q;
	logic          over_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] num_top;

	assign num_top = DW'(num[NW-1:QW]);
	assign shifted = {rem_q, low_q[QW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient at or above 2^48 exactly when the upper numerator part reaches den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_top;
			low_q  <= num[QW-1:0];
			den_q  <= den;
			over_q <= num_top >= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			low_q <= {low_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign over = over_q;
	assign quo  = low_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import skl_pkg::*;

	// one dimension of the two gaussians, as it crosses the dim channel
	typedef struct packed {
		logic signed [DATA_W-1:0] mean_a;
		logic        [DATA_W-1:0] var_a;
		logic signed [DATA_W-1:0] mean_b;
		logic        [DATA_W-1:0] var_b;
		logic                     final_dim;
	} dim_item_t;

	// one total, as it crosses the res channel
	typedef struct packed {
		logic [ACC_W-1:0] divergence;
		logic             saturated;
	} kl_result_t;

	typedef enum logic [0:0] {ROW_DIM, ROW_FLOOR} row_kind_e;

	// a directed row is either a dimension item or a floor write
	typedef struct {
		row_kind_e        kind;
		dim_item_t        item;
		logic [DATA_W-1:0] floor_val;
		bit               typed;
		kl_result_t       typed_res;
	} stim_row_t;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 200;
	localparam int HOLD_CYCLES    = 3000;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 240;
	localparam int N_PHASES       = 6;
	localparam int N_DIRECTED     = 22;

	localparam logic [DATA_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MEAN_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAR_MAX  = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] F10      = MIN_VAR_RESET;

	localparam kl_result_t ZERO_RES = '{'0, 1'b0};
	localparam kl_result_t CLIP_RES = '{ACC_MAX, 1'b1};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [DATA_W-1:0] cfg_data;

	skl_dim_if dim_ch ();
	skl_res_if res_ch ();

	symmetric_kl_diag_gaussian u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.dim      (dim_ch),
		.res      (res_ch)
	);

	// model of the block: floor register, running total and clip flag
	logic [DATA_W-1:0] floor_model;
	logic [ACC_W-1:0]  kl_total;
	logic              kl_clipped;

	// totals still owed by the block, oldest first
	kl_result_t pending_totals [$];

	int mismatch_count;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int hold_left;

	// directed rows: typed totals only where they are obvious
	stim_row_t directed_rows [N_DIRECTED] = '{
		// right after reset, equal gaussians at the floor give nothing
		'{ROW_DIM,   '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}, '0, 1'b1, ZERO_RES},
		// widest mean gap five times, still just under the top
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b0}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b0}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b0}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b0}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b0}, '0, 1'b0, ZERO_RES},
		// sixth one overflows the accumulator
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b1}, '0, 1'b1, CLIP_RES},
		// total and clip flag cleared after the emission
		'{ROW_DIM,   '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}, '0, 1'b1, ZERO_RES},
		'{ROW_DIM,   '{MEAN_MIN, VAR_MAX, MEAN_MAX, VAR_MAX, 1'b1}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{32'h0, VAR_MAX, 32'h0, 32'h0, 1'b0}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{32'h0, 32'h0, 32'h0, VAR_MAX, 1'b1}, '0, 1'b0, ZERO_RES},
		// -5.0 with 3.0 and 5.0: both raised to the floor, so identical
		'{ROW_DIM,   '{32'hFFFB_0000, 32'h0003_0000, 32'hFFFB_0000, 32'h0005_0000, 1'b1},
			'0, 1'b1, ZERO_RES},
		// one lsb either side of the floor
		'{ROW_DIM,   '{32'h0001_0000, F10 - 32'd1, 32'hFFFF_0000, F10 + 32'd1, 1'b1},
			'0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0},
			'0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1},
			'0, 1'b0, ZERO_RES},
		// zero floor behaves as one lsb
		'{ROW_FLOOR, '0, 32'h0, 1'b0, ZERO_RES},
		// single term too big for 48 bits
		'{ROW_DIM,   '{MEAN_MAX, 32'h0, MEAN_MIN, 32'h0, 1'b1}, '0, 1'b1, CLIP_RES},
		// zero variances with a zero floor: division still defined
		'{ROW_DIM,   '{32'h1234_5678, 32'h0, 32'h1234_5678, 32'h0, 1'b1}, '0, 1'b1, ZERO_RES},
		'{ROW_FLOOR, '0, VAR_MAX, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{MEAN_MAX, 32'h1234, MEAN_MIN, 32'h0, 1'b1}, '0, 1'b0, ZERO_RES},
		'{ROW_DIM,   '{32'h1, 32'h0, 32'h0, 32'hFFFF_FFFE, 1'b1}, '0, 1'b0, ZERO_RES},
		'{ROW_FLOOR, '0, F10, 1'b0, ZERO_RES}
	};

	// adds one dimension to the model total; hands back the total on the last one
	function automatic void accumulate_sym_kl(input dim_item_t item, output bit emits,
			output kl_result_t total);
		logic [DATA_W-1:0] fv, v1, v2, vdiff;
		logic [DATA_W:0]   dmean, amean;
		logic [127:0]      num, den, quo;
		logic [ACC_W-1:0]  term;
		logic [ACC_W:0]    sum;
		bit                clip;
		clip = 1'b0;
		fv = (floor_model == '0) ? DATA_W'(1) : floor_model;
		v1 = (item.var_a < fv) ? fv : item.var_a;
		v2 = (item.var_b < fv) ? fv : item.var_b;
		// mean gap in 33 bits, then its magnitude
		dmean = {item.mean_a[DATA_W-1], item.mean_a} - {item.mean_b[DATA_W-1], item.mean_b};
		amean = dmean[DATA_W] ? -dmean : dmean;
		vdiff = (v1 > v2) ? v1 - v2 : v2 - v1;
		// ((v1-v2)^2 + d^2 (v1+v2)) / (v1 v2), all exact in 128 bits
		num = 128'(amean) * 128'(amean) * (128'(v1) + 128'(v2))
			+ ((128'(vdiff) * 128'(vdiff)) << FRAC_W);
		den = 128'(v1) * 128'(v2);
		quo = num / den;
		if (quo > 128'(ACC_MAX)) begin
			term = ACC_MAX;
			clip = 1'b1;
		end else begin
			term = quo[ACC_W-1:0];
		end
		sum = {1'b0, kl_total} + {1'b0, term};
		if (sum > {1'b0, ACC_MAX}) begin
			sum = {1'b0, ACC_MAX};
			clip = 1'b1;
		end
		kl_total = sum[ACC_W-1:0];
		kl_clipped = kl_clipped | clip;
		emits = item.final_dim;
		total = '{kl_total, kl_clipped};
		if (emits) begin
			kl_total = '0;
			kl_clipped = 1'b0;
		end
	endfunction

	// means: extremes, small values around zero, anything
	function automatic logic [DATA_W-1:0] pick_mean();
		case ($urandom_range(5))
			0: return MEAN_MAX;
			1: return MEAN_MIN;
			2, 3: return DATA_W'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	// variances: zero, top, around the floor, small, anything
	function automatic logic [DATA_W-1:0] pick_var();
		case ($urandom_range(7))
			0: return '0;
			1: return VAR_MAX;
			2: return floor_model + DATA_W'($urandom_range(0, 2)) - DATA_W'(1);
			3: return DATA_W'($urandom_range(0, 32'h00FF_FFFF));
			default: return $urandom;
		endcase
	endfunction

	function automatic dim_item_t random_dim(input bit last);
		dim_item_t item;
		item.mean_a    = pick_mean();
		item.var_a     = pick_var();
		item.mean_b    = pick_mean();
		item.var_b     = pick_var();
		item.final_dim = last;
		return item;
	endfunction

	// offer one item, with random gaps ahead of it, and log what it owes
	task automatic offer_dim(input dim_item_t item, input bit typed,
			input kl_result_t typed_res);
		bit         emits;
		kl_result_t total;
		while ($urandom_range(99) < send_idle_pct) begin
			dim_ch.valid <= 1'b0;
			@(posedge clk);
		end
		dim_ch.valid     <= 1'b1;
		dim_ch.mean_a    <= item.mean_a;
		dim_ch.var_a     <= item.var_a;
		dim_ch.mean_b    <= item.mean_b;
		dim_ch.var_b     <= item.var_b;
		dim_ch.final_dim <= item.final_dim;
		do @(posedge clk); while (!dim_ch.ready);
		accumulate_sym_kl(item, emits, total);
		if (emits)
			pending_totals.push_back(typed ? typed_res : total);
	endtask

	// every owed total back, then time for a dimension still in the pipe
	task automatic drain_block();
		dim_ch.valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_floor(input logic [DATA_W-1:0] value);
		drain_block();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		floor_model = value;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result check against the oldest owed total
	always @(posedge clk) begin
		kl_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_totals.size() == 0) begin
				$display("%0t: unexpected item divergence %h saturated %b", $time,
					res_ch.divergence, res_ch.saturated);
				mismatch_count++;
			end else begin
				want = pending_totals.pop_front();
				if (res_ch.divergence !== want.divergence) begin
					$display("%0t: divergence expected %h actual %h", $time,
						want.divergence, res_ch.divergence);
					mismatch_count++;
				end
				if (res_ch.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, res_ch.saturated);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on stretches with no handshake at all
	always @(posedge clk) begin
		if ((dim_ch.valid && dim_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int         sent;
		int         group_len;
		logic [DATA_W-1:0] floor_plan;
		mismatch_count = 0;
		quiet_cycles   = 0;
		hold_request   = 1'b0;
		hold_left      = 0;
		send_idle_pct  = 11;
		recv_stall_pct = 61;
		floor_model    = MIN_VAR_RESET;
		kl_total       = '0;
		kl_clipped     = 1'b0;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_data         <= '0;
		dim_ch.valid     <= 1'b0;
		dim_ch.mean_a    <= '0;
		dim_ch.var_a     <= '0;
		dim_ch.mean_b    <= '0;
		dim_ch.var_b     <= '0;
		dim_ch.final_dim <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_FLOOR)
				write_floor(directed_rows[i].floor_val);
			else
				offer_dim(directed_rows[i].item, directed_rows[i].typed,
					directed_rows[i].typed_res);
		end

		// random phases: each starts idle with a new floor; idling pattern every two
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: floor_plan = MIN_VAR_RESET;
				1: floor_plan = DATA_W'($urandom_range(1, 32'h0010_0000));
				2: floor_plan = '0;
				3: floor_plan = DATA_W'(1);
				4: floor_plan = VAR_MAX;
				default: floor_plan = $urandom;
			endcase
			write_floor(floor_plan);
			case (phase / 2)
				0: begin
					send_idle_pct  = 11;
					recv_stall_pct = 61;
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 11;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			// the sender keeps going while the receiver sits out, so the input backs up
			if (phase == 1)
				hold_request = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// mostly short groups, now and then a long one to reach the top
				group_len = ($urandom_range(9) == 0) ? $urandom_range(12, 40)
					: $urandom_range(1, 6);
				for (int j = 0; j < group_len; j++)
					offer_dim(random_dim(j == group_len - 1), 1'b0, ZERO_RES);
				sent += group_len;
			end
		end

		drain_block();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
